[src/rdw_pkg.sv]
// ----------------------------------------------------------------------------
// rdw_pkg
// Shared types and constants for the decaying-window running average.
// ----------------------------------------------------------------------------
package rdw_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CNT_BITS        = 17;
    localparam int WIN_BITS        = 16;
    localparam int HELD_BITS       = 16;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 16'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

[src/running_average_decaying_window.sv]
// ----------------------------------------------------------------------------
// running_average_decaying_window
// Approximate moving average of signed Q8.8 samples with a decaying sum.
// ----------------------------------------------------------------------------
// s_valid/s_ready/s_sample take one sample item; m_valid/m_ready return one
// result item per sample: m_average (sum / count, truncated toward zero,
// saturated to the sample range) and m_samples_held (count after the step).
// cfg_valid/cfg_ready/cfg_window_size write the window register; write it
// only while no item is in flight.
// From acceptance to m_valid: the sample is added at the accepting edge,
// ST_LOAD takes the magnitude of the sum, the bit-serial restoring divider
// runs in ST_DIV, and ST_FINISH decays the sum (when the count exceeds the
// window) and loads the output register.
// s_ready returns the cycle after ST_FINISH, so a new sample is taken only
// once the previous one is through.
// Reset (aresetn, synchronous, active low) clears sum and count, sets the
// window to 16 and empties the output register.
// If m_ready is low the result holds in the output register; the next item
// is processed and then waits until the register is free.
// ----------------------------------------------------------------------------
module running_average_decaying_window #(
    parameter int SAMPLE_BITS = rdw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdw_pkg::WIN_BITS-1:0]        cfg_window_size,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_average,
    output logic [rdw_pkg::HELD_BITS-1:0]       m_samples_held
);

    localparam int CNT_BITS  = rdw_pkg::CNT_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int STEP_BITS = $clog2(SUM_BITS);

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] AVG_MAX =
        {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] AVG_MIN =
        {{(SUM_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);

    rdw_pkg::state_t state_reg, state_next;

    logic [rdw_pkg::WIN_BITS-1:0]   window_reg, window_next;
    logic signed [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [CNT_BITS-1:0]            count_reg, count_next;
    logic                           neg_reg, neg_next;
    logic [CNT_BITS-1:0]            rem_reg, rem_next;
    logic [SUM_BITS-1:0]            quo_reg, quo_next;
    logic [STEP_BITS-1:0]           step_reg, step_next;
    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0]  avg_reg, avg_next;
    logic [rdw_pkg::HELD_BITS-1:0]  held_reg, held_next;

    logic signed [SUM_BITS:0]       sum_ext;
    logic signed [SUM_BITS-1:0]     sum_sat;
    logic [CNT_BITS:0]              trial;
    logic [CNT_BITS:0]              diff;
    logic signed [SUM_BITS-1:0]     quo_signed;
    logic                           out_free;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == rdw_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_average      = avg_reg;
    assign m_samples_held = held_reg;

    assign out_free = !m_valid_reg || m_ready;

    // saturating accumulate
    assign sum_ext = {sum_reg[SUM_BITS-1], sum_reg} + (SUM_BITS+1)'(s_sample);
    always_comb begin
        if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
            sum_sat = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_ext[SUM_BITS-1:0];
        end
    end

    // restoring divider step
    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff  = trial - {1'b0, count_reg};

    assign quo_signed = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rdw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rdw_pkg::ST_LOAD;
                end
            end
            rdw_pkg::ST_LOAD: begin
                state_next = rdw_pkg::ST_DIV;
            end
            rdw_pkg::ST_DIV: begin
                if (step_reg == STEP_LAST) begin
                    state_next = rdw_pkg::ST_FINISH;
                end
            end
            rdw_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rdw_pkg::ST_IDLE;
                end
            end
            default: state_next = rdw_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        window_next  = window_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        avg_next     = avg_reg;
        held_next    = held_reg;

        if (cfg_valid) begin
            window_next = cfg_window_size;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rdw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sum_next   = sum_sat;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            rdw_pkg::ST_LOAD: begin
                neg_next  = sum_reg[SUM_BITS-1];
                quo_next  = sum_reg[SUM_BITS-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
                rem_next  = '0;
                step_next = '0;
            end
            rdw_pkg::ST_DIV: begin
                if (!diff[CNT_BITS]) begin
                    rem_next = diff[CNT_BITS-1:0];
                end else begin
                    rem_next = trial[CNT_BITS-1:0];
                end
                quo_next  = {quo_reg[SUM_BITS-2:0], !diff[CNT_BITS]};
                step_next = step_reg + STEP_BITS'(1);
            end
            rdw_pkg::ST_FINISH: begin
                if (out_free) begin
                    if (quo_signed > AVG_MAX) begin
                        avg_next = AVG_MAX[SAMPLE_BITS-1:0];
                    end else if (quo_signed < AVG_MIN) begin
                        avg_next = AVG_MIN[SAMPLE_BITS-1:0];
                    end else begin
                        avg_next = quo_signed[SAMPLE_BITS-1:0];
                    end
                    if (count_reg > {1'b0, window_reg}) begin
                        count_next = {1'b0, window_reg};
                        sum_next   = sum_reg - quo_signed;
                        held_next  = window_reg;
                    end else begin
                        held_next  = count_reg[rdw_pkg::HELD_BITS-1:0];
                    end
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rdw_pkg::ST_IDLE;
            window_reg  <= rdw_pkg::WINDOW_RESET;
            sum_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        avg_reg  <= avg_next;
        held_reg <= held_next;
    end

endmodule
